// ----- src/lzb_pkg.sv -----
package lzb_pkg;

   localparam int HistoryDepthDefault = 4096;
   localparam int GammaBitsDefault    = 16;
   localparam int CapW                = 25;
   localparam logic [CapW-1:0] CapReset = 25'd65536;

   localparam logic [2:0] PH_FIRST   = 3'd0;
   localparam logic [2:0] PH_FLAG    = 3'd1;
   localparam logic [2:0] PH_LIT     = 3'd2;
   localparam logic [2:0] PH_GSTOP   = 3'd3;
   localparam logic [2:0] PH_GDATA   = 3'd4;
   localparam logic [2:0] PH_OFFBYTE = 3'd5;
   localparam logic [2:0] PH_OFFBITS = 3'd6;
   localparam logic [2:0] PH_COPY    = 3'd7;

   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_END = 2'd1;
   localparam logic [1:0] ST_CAP = 2'd2;
   localparam logic [1:0] ST_ERR = 2'd3;

   localparam logic [1:0] WN_BYTE = 2'd0;
   localparam logic [1:0] WN_ADV  = 2'd1;
   localparam logic [1:0] WN_DONE = 2'd2;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_ADV  = 1'b1;

   // One queued transaction between front and back.
   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
   } item_type;

endpackage

// ----- src/lz_backward_decompressor.sv -----
// Backward LZ (ZX7b-style) decompressor. Each transaction is either a packed
// byte or an advance command for a pending match copy, and returns exactly one
// response carrying the produced byte (if any), what the decoder needs next,
// and a status. A short queue sits in front of the decoder; the decoder handles
// one transaction at a time in the steps take, history read and update, and
// holds the update while the previous response is stalled. csr writes
// set the output capacity and should only be issued while the block is idle.
module lz_backward_decompressor #(
   parameter int HISTORY_DEPTH = lzb_pkg::HistoryDepthDefault,
   parameter int GAMMA_BITS    = lzb_pkg::GammaBitsDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_command,
   input  logic [7:0]               req_data_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_byte_valid,
   output logic [1:0]               rsp_wants_next,
   output logic [1:0]               rsp_status,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [lzb_pkg::CapW-1:0] csr_out_capacity
);

   lzb_pkg::item_type in_item, q_item;
   logic q_valid, q_take;
   logic [lzb_pkg::CapW-1:0] cap_ff;

   assign in_item.command   = req_command;
   assign in_item.data_byte = req_data_byte;
   assign csr_ready = 1'b1;

   // Capacity register.
   always_ff @(posedge clock) begin
      if (reset) cap_ff <= lzb_pkg::CapReset;
      else if (csr_valid && csr_ready) cap_ff <= csr_out_capacity;
   end

   lzb_queue u_queue (
      .clock(clock), .reset(reset), .in_valid(req_valid), .in_stall(req_stall),
      .in_item(in_item), .out_valid(q_valid), .out_take(q_take), .out_item(q_item)
   );

   lzb_core #(.HISTORY_DEPTH(HISTORY_DEPTH), .GAMMA_BITS(GAMMA_BITS)) u_core (
      .clock(clock), .reset(reset), .capacity(cap_ff), .in_valid(q_valid),
      .in_take(q_take), .in_item(q_item), .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall), .rsp_out_byte(rsp_out_byte),
      .rsp_byte_valid(rsp_byte_valid), .rsp_wants_next(rsp_wants_next),
      .rsp_status(rsp_status)
   );

   // A finished decoder never produces another byte.
   a_done_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_wants_next == lzb_pkg::WN_DONE
      |=> !(rsp_valid && rsp_byte_valid && rsp_wants_next != lzb_pkg::WN_DONE))
      else $error("byte after finish");

   // The decoder only takes an item while the queue holds one.
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      q_take |-> q_valid)
      else $error("take without item");

endmodule

// ----- src/lzb_queue.sv -----
// Two-entry queue that decouples the input front from the decoder back.
module lzb_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_stall,
   input  lzb_pkg::item_type  in_item,
   output logic               out_valid,
   input  logic               out_take,
   output lzb_pkg::item_type  out_item
);

   lzb_pkg::item_type slot_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_stall  = cnt_ff == 2'd2;
   assign push      = in_valid && !in_stall;
   assign out_valid = cnt_ff != 2'd0;
   assign pop       = out_valid && out_take;
   assign out_item  = slot_ff[rd_ff];

   // Occupancy follows pushes and pops.
   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 2'd1;
      else if (pop && !push) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= in_item;
   end

endmodule

// ----- src/lzb_core.sv -----
// Decoder back end: parses bits, produces literals and copies from history.
module lzb_core #(
   parameter int HISTORY_DEPTH = lzb_pkg::HistoryDepthDefault,
   parameter int GAMMA_BITS    = lzb_pkg::GammaBitsDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [lzb_pkg::CapW-1:0] capacity,
   input  logic                     in_valid,
   output logic                     in_take,
   input  lzb_pkg::item_type        in_item,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_byte_valid,
   output logic [1:0]               rsp_wants_next,
   output logic [1:0]               rsp_status
);

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int GW = GAMMA_BITS + 1;
   localparam int CW = lzb_pkg::CapW;

   // Sequencer: idle, then a history read state for every transaction, then the update state.
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;

   logic [7:0]    hist_mem [HISTORY_DEPTH];
   logic [7:0]    rd_data_ff;
   logic [1:0]    seq_ff, seq_in;
   lzb_pkg::item_type cur_ff;

   logic [AW-1:0] wp_ff, wp_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [7:0]    buf_ff, buf_in;
   logic [7:0]    mask_ff, mask_in;
   logic [2:0]    ph_ff, ph_in;
   logic [GW-1:0] gam_ff, gam_in;
   logic [GW-1:0] rem_ff, rem_in;
   logic [11:0]   off_ff, off_in;
   logic [AW:0]   dist_ff, dist_in;
   logic [2:0]    obits_ff, obits_in;
   logic          fin_ff, fin_in;
   logic [1:0]    fst_ff, fst_in;

   logic          ov_ff;
   logic [7:0]    ob_ff, ob_in;
   logic          bv_ff, bv_in;
   logic [1:0]    st_ff, st_in;
   logic [1:0]    wn_ff;

   logic          out_free;
   logic          wr_en;
   logic [7:0]    wr_data;
   logic [AW-1:0] rd_addr;

   assign out_free = !ov_ff || !rsp_stall;
   assign in_take  = seq_ff == S_IDLE && in_valid;
   assign rd_addr  = wp_ff - dist_ff[AW-1:0];

   always_comb begin
      seq_in = seq_ff;
      unique case (seq_ff)
         S_IDLE: if (in_valid) seq_in = S_READ;
         S_READ: seq_in = S_EXEC;
         S_EXEC: if (out_free) seq_in = S_IDLE;
         default: seq_in = S_IDLE;
      endcase
   end

   // One parse step per transaction; the bit drain is at most eight narrow steps.
   always_comb begin
      logic [8:0]    dist9;
      logic [12:0]   full_off;
      logic [GW-1:0] v;
      logic [3:0]    hb;
      logic          b;
      logic          stop;
      wp_in = wp_ff; cnt_in = cnt_ff; buf_in = buf_ff; mask_in = mask_ff;
      ph_in = ph_ff; gam_in = gam_ff; rem_in = rem_ff; off_in = off_ff;
      dist_in = dist_ff; obits_in = obits_ff; fin_in = fin_ff; fst_in = fst_ff;
      ob_in = 8'd0; bv_in = 1'b0; st_in = lzb_pkg::ST_OK;
      wr_en = 1'b0; wr_data = 8'd0;
      dist9 = '0; full_off = '0; v = '0; hb = '0; b = 1'b0;
      stop = 1'b1;
      if (fin_ff) begin
         st_in = fst_ff;
      end else if (cur_ff.command == lzb_pkg::CMD_ADV) begin
         if (ph_ff != lzb_pkg::PH_COPY) st_in = lzb_pkg::ST_ERR;
         else begin
            wr_en = 1'b1; wr_data = rd_data_ff;
            ob_in = rd_data_ff; bv_in = 1'b1;
            wp_in = wp_ff + 1'b1; cnt_in = cnt_ff + 1'b1;
            if (rem_ff != '0) rem_in = rem_ff - 1'b1;
            if (cnt_in >= capacity) begin
               fin_in = 1'b1; fst_in = lzb_pkg::ST_CAP; st_in = lzb_pkg::ST_CAP;
            end else if (rem_in == '0) begin
               ph_in = lzb_pkg::PH_FLAG; stop = 1'b0;
            end
         end
      end else if (ph_ff == lzb_pkg::PH_COPY) begin
         st_in = lzb_pkg::ST_ERR;
      end else if (ph_ff == lzb_pkg::PH_FIRST || ph_ff == lzb_pkg::PH_LIT) begin
         if (cnt_ff >= capacity) begin
            fin_in = 1'b1; fst_in = lzb_pkg::ST_CAP; st_in = lzb_pkg::ST_CAP;
         end else begin
            wr_en = 1'b1; wr_data = cur_ff.data_byte;
            ob_in = cur_ff.data_byte; bv_in = 1'b1;
            wp_in = wp_ff + 1'b1; cnt_in = cnt_ff + 1'b1;
            if (cnt_in >= capacity) begin
               fin_in = 1'b1; fst_in = lzb_pkg::ST_CAP; st_in = lzb_pkg::ST_CAP;
            end else begin
               ph_in = lzb_pkg::PH_FLAG; stop = 1'b0;
            end
         end
      end else if (ph_ff == lzb_pkg::PH_OFFBYTE) begin
         if (!cur_ff.data_byte[7]) begin
            dist9 = {1'b0, cur_ff.data_byte} + 9'd1;
            if (CW'(dist9) > cnt_ff) begin
               fin_in = 1'b1; fst_in = lzb_pkg::ST_ERR; st_in = lzb_pkg::ST_ERR;
            end else begin
               dist_in = (AW+1)'(dist9); ph_in = lzb_pkg::PH_COPY;
            end
         end else begin
            off_in = {5'd0, cur_ff.data_byte[6:0]};
            obits_in = 3'd0; ph_in = lzb_pkg::PH_OFFBITS; stop = 1'b0;
         end
      end else begin
         buf_in = cur_ff.data_byte; mask_in = 8'd0;
         stop = 1'b0;
         // The leading bit is taken below with the top-bit mask.
         mask_in = 8'd0;
      end
      // Bit loop: first iteration handles a fresh byte's top bit.
      for (int i = 0; i < 8; i++) begin
         logic take;
         take = 1'b0;
         if (!stop && !fin_in && (ph_in == lzb_pkg::PH_FLAG ||
             ph_in == lzb_pkg::PH_GSTOP || ph_in == lzb_pkg::PH_GDATA ||
             ph_in == lzb_pkg::PH_OFFBITS)) begin
            if (i == 0 && cur_ff.command == lzb_pkg::CMD_BYTE && !fin_ff &&
                (ph_ff == lzb_pkg::PH_FLAG || ph_ff == lzb_pkg::PH_GSTOP ||
                 ph_ff == lzb_pkg::PH_GDATA || ph_ff == lzb_pkg::PH_OFFBITS)) begin
               mask_in = 8'h80; take = 1'b1;
            end else if (mask_in[7:1] != 7'd0) begin
               mask_in = mask_in >> 1; take = 1'b1;
            end
         end
         if (take) begin
            b = (buf_in & mask_in) != 8'd0;
            unique case (ph_in)
               lzb_pkg::PH_FLAG: begin
                  if (b) begin gam_in = GW'(1); ph_in = lzb_pkg::PH_GSTOP; end
                  else ph_in = lzb_pkg::PH_LIT;
               end
               lzb_pkg::PH_GSTOP: begin
                  if (!b) ph_in = lzb_pkg::PH_GDATA;
                  else if (gam_in[7:0] == 8'hFF) begin
                     fin_in = 1'b1; fst_in = lzb_pkg::ST_END; st_in = lzb_pkg::ST_END;
                  end else begin
                     rem_in = gam_in + 1'b1; ph_in = lzb_pkg::PH_OFFBYTE;
                  end
               end
               lzb_pkg::PH_GDATA: begin
                  v = {gam_in[GW-2:0], b};
                  if (gam_in[GW-1] || v[GW-1]) begin
                     fin_in = 1'b1; fst_in = lzb_pkg::ST_ERR; st_in = lzb_pkg::ST_ERR;
                  end else begin
                     gam_in = v; ph_in = lzb_pkg::PH_GSTOP;
                  end
               end
               default: begin
                  hb = {off_in[9:7], b};
                  off_in = {1'b0, hb, off_in[6:0]};
                  obits_in = obits_in + 3'd1;
                  if (obits_in >= 3'd4) begin
                     full_off = {1'b0, off_in} + 13'd129;
                     if (CW'(full_off) > cnt_ff ||
                         32'(full_off) > 32'(HISTORY_DEPTH)) begin
                        fin_in = 1'b1; fst_in = lzb_pkg::ST_ERR;
                        st_in = lzb_pkg::ST_ERR;
                     end else begin
                        dist_in = (AW+1)'(full_off); ph_in = lzb_pkg::PH_COPY;
                     end
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= S_IDLE; wp_ff <= '0; cnt_ff <= '0; buf_ff <= '0; mask_ff <= '0;
         ph_ff <= lzb_pkg::PH_FIRST; gam_ff <= GW'(1); rem_ff <= '0; off_ff <= '0;
         dist_ff <= '0; obits_ff <= '0; fin_ff <= 1'b0; fst_ff <= lzb_pkg::ST_OK;
         ov_ff <= 1'b0;
      end else begin
         seq_ff <= seq_in;
         if (ov_ff && !rsp_stall) ov_ff <= 1'b0;
         if (seq_ff == S_EXEC && out_free) begin
            wp_ff <= wp_in; cnt_ff <= cnt_in; buf_ff <= buf_in; mask_ff <= mask_in;
            ph_ff <= ph_in; gam_ff <= gam_in; rem_ff <= rem_in; off_ff <= off_in;
            dist_ff <= dist_in; obits_ff <= obits_in; fin_ff <= fin_in;
            fst_ff <= fst_in; ov_ff <= 1'b1;
         end
      end
   end

   // History memory and output payload.
   always_ff @(posedge clock) begin
      if (in_take) cur_ff <= in_item;
      if (seq_ff == S_READ) rd_data_ff <= hist_mem[rd_addr];
      if (seq_ff == S_EXEC && out_free && wr_en) hist_mem[wp_ff] <= wr_data;
      if (seq_ff == S_EXEC && out_free) begin
         ob_ff <= ob_in; bv_ff <= bv_in; st_ff <= st_in;
         wn_ff <= fin_in ? lzb_pkg::WN_DONE :
                  (ph_in == lzb_pkg::PH_COPY ? lzb_pkg::WN_ADV : lzb_pkg::WN_BYTE);
      end
   end

   assign rsp_valid      = ov_ff;
   assign rsp_out_byte   = ob_ff;
   assign rsp_byte_valid = bv_ff;
   assign rsp_wants_next = wn_ff;
   assign rsp_status     = st_ff;

endmodule
